>>> sv/rrq_pkg.sv
// Shared types and constants of the round-robin ready queue.
`default_nettype none
package rrq_pkg;

	localparam int THREAD_W = 8;
	localparam int COUNT_W  = 5;

	typedef enum logic [1:0] {
		OP_SCHEDULE  = 2'd0,
		OP_READY     = 2'd1,
		OP_NOT_READY = 2'd2,
		OP_NOP       = 2'd3
	} op_e;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_e;

	// Per-cycle command broadcast to every queue cell
	typedef struct packed {
		logic sched;
		logic append;
		logic remove;
	} rrq_cmd_t;

endpackage
`default_nettype wire

>>> sv/rrq_if.sv
// Channel interfaces: request, response and configuration write.
`default_nettype none
interface rrq_req_if;
	import rrq_pkg::*;
	logic                valid;
	logic                ready;
	op_e                 operation;
	logic [THREAD_W-1:0] thread_id;
	modport source (output valid, output operation, output thread_id, input ready);
	modport sink   (input valid, input operation, input thread_id, output ready);
endinterface

interface rrq_rsp_if;
	import rrq_pkg::*;
	logic                valid;
	logic                ready;
	logic [THREAD_W-1:0] running_thread;
	logic                switched;
	status_e             status;
	logic [COUNT_W-1:0]  queue_count;
	modport source (output valid, output running_thread, output switched, output status,
		output queue_count, input ready);
	modport sink   (input valid, input running_thread, input switched, input status,
		input queue_count, output ready);
endinterface

interface rrq_cfg_if;
	import rrq_pkg::*;
	logic                valid;
	logic                ready;
	logic [THREAD_W-1:0] init_id;
	modport source (output valid, output init_id, input ready);
	modport sink   (input valid, input init_id, output ready);
endinterface
`default_nettype wire

>>> sv/rrq_cell.sv
// One queue slot: holds an id, matches it and takes its right neighbor on shifts.
`default_nettype none
module rrq_cell #(
	parameter int ID_BITS = 8,
	parameter int CNT_W   = 5,
	parameter int IDX     = 0
) (
	input  wire                   clk,
	input  rrq_pkg::rrq_cmd_t     cmd,
	input  wire [CNT_W-1:0]       count,
	input  wire [ID_BITS-1:0]     id,
	input  wire [ID_BITS-1:0]     running,
	input  wire [ID_BITS-1:0]     next_entry,
	input  wire                   found_in,
	output logic [ID_BITS-1:0]    entry,
	output logic                  found_out
);
	import rrq_pkg::*;

	logic [ID_BITS-1:0] entry_q;
	logic               occupied;
	logic               is_tail;
	logic               is_free;
	logic               match;

	assign occupied  = count > CNT_W'(IDX);
	assign is_tail   = count == CNT_W'(IDX + 1);
	assign is_free   = count == CNT_W'(IDX);
	assign match     = occupied && (entry_q == id);
	assign found_out = found_in | match;
	assign entry     = entry_q;

	always_ff @(posedge clk) begin
		if (cmd.sched && occupied) begin
			// old running id drops in behind the last waiting entry
			entry_q <= is_tail ? running : next_entry;
		end else if (cmd.append && is_free) begin
			entry_q <= id;
		end else if (cmd.remove && occupied && found_out) begin
			entry_q <= next_entry;
		end
	end

endmodule
`default_nettype wire

>>> sv/round_robin_ready_queue.sv
// Round-robin ready queue of thread ids with one running thread.
//
// Channels: req carries an operation (schedule, make ready, make not ready,
// no-op) and a thread id; rsp returns one result per request with the
// running thread, the switched flag, a status code and the queue count;
// cfg writes the initial thread id, which becomes the running thread and
// empties the queue. cfg is always ready; the user must use it only while
// idle; the block itself does not enforce this. The row of queue cells
// compares, shifts and appends together and the result is registered, so
// rsp.valid rises in the cycle after a request is accepted. A new request
// is accepted every cycle as long as the response register is empty or
// is being taken; when the receiver stalls, req.ready stays low until the
// held response is accepted. Removal of an id ripples a found flag through
// the whole row, which sets the cycle length for deep queues.
// Reset empties the queue and makes thread 0 the running thread.
`default_nettype none
module round_robin_ready_queue #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 8
) (
	input  wire    clk,
	input  wire    arst_n,
	rrq_req_if.sink   req,
	rrq_rsp_if.source rsp,
	rrq_cfg_if.sink   cfg
);
	import rrq_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [CNT_W-1:0]   count_q;
	logic [ID_BITS-1:0] running_q;
	logic               rsp_valid_q;
	logic [THREAD_W-1:0] rsp_running_q;
	logic               rsp_switched_q;
	status_e            rsp_status_q;
	logic [COUNT_W-1:0] rsp_count_q;

	logic               req_fire;
	logic               cfg_fire;
	logic [ID_BITS-1:0] id_in;
	logic               empty;
	logic               full;
	logic               found;
	rrq_cmd_t           cmd;
	logic [CNT_W-1:0]   count_d;
	logic [ID_BITS-1:0] running_d;
	logic               switched_d;
	status_e            status_d;

	logic [ID_BITS-1:0] entry_w [QUEUE_DEPTH];
	logic [ID_BITS-1:0] next_w  [QUEUE_DEPTH];
	logic               found_w [QUEUE_DEPTH+1];

	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid;
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign req_fire  = req.valid && req.ready;
	assign id_in     = ID_BITS'(req.thread_id);
	assign empty     = count_q == '0;
	assign full      = count_q == CNT_W'(QUEUE_DEPTH);

	always_comb begin
		cmd.sched  = req_fire && (req.operation == OP_SCHEDULE) && !empty;
		cmd.append = req_fire && (req.operation == OP_READY) && !full;
		cmd.remove = req_fire && (req.operation == OP_NOT_READY);
	end

	assign found_w[0] = 1'b0;

	genvar i;
	generate
		for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
			if (i == QUEUE_DEPTH - 1) begin : g_last
				assign next_w[i] = running_q;
			end else begin : g_mid
				assign next_w[i] = entry_w[i+1];
			end
			rrq_cell #(
				.ID_BITS (ID_BITS),
				.CNT_W   (CNT_W),
				.IDX     (i)
			) u_cell (
				.clk        (clk),
				.cmd        (cmd),
				.count      (count_q),
				.id         (id_in),
				.running    (running_q),
				.next_entry (next_w[i]),
				.found_in   (found_w[i]),
				.entry      (entry_w[i]),
				.found_out  (found_w[i+1])
			);
		end
	endgenerate

	assign found = found_w[QUEUE_DEPTH];

	// result decode
	always_comb begin
		count_d    = count_q;
		running_d  = running_q;
		switched_d = 1'b0;
		status_d   = ST_OK;
		unique case (req.operation)
			OP_SCHEDULE: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					running_d  = entry_w[0];
					switched_d = 1'b1;
				end
			end
			OP_READY: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_NOT_READY: begin
				if (found) begin
					count_d = count_q - CNT_W'(1);
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			OP_NOP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			running_q <= '0;
		end else if (cfg_fire) begin
			count_q   <= '0;
			running_q <= ID_BITS'(cfg.init_id);
		end else if (req_fire) begin
			count_q   <= count_d;
			running_q <= running_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			rsp_running_q  <= THREAD_W'(running_d);
			rsp_switched_q <= switched_d;
			rsp_status_q   <= status_d;
			rsp_count_q    <= COUNT_W'(count_d);
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.running_thread = rsp_running_q;
	assign rsp.switched       = rsp_switched_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.queue_count    = rsp_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> rsp.valid)
		else $error("accepted request gave no response");

	a_sched_switch: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && !cfg_fire && req.operation == OP_SCHEDULE && !empty)
		|=> (rsp.switched && rsp.status == ST_OK && $stable(count_q)))
		else $error("schedule on non-empty queue did not switch");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && !cfg_fire && req.operation == OP_READY && full)
		|=> (rsp.status == ST_FULL && $stable(count_q)))
		else $error("append to full queue not dropped");

	a_count_out: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && !cfg_fire) |=> (rsp.queue_count == COUNT_W'(count_q)))
		else $error("reported count differs from queue");

endmodule
`default_nettype wire

>>> tb/round_robin_ready_queue_tb.sv
// Self-checking testbench for the round-robin ready queue: directed corner cases and random traffic.
`timescale 1ns / 100ps
module round_robin_ready_queue_tb;
	import rrq_pkg::*;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS     = 8;

	typedef struct {
		logic [THREAD_W-1:0] running_thread;
		logic                switched;
		status_e             status;
		logic [COUNT_W-1:0]  queue_count;
	} sched_result_t;

	logic clk;
	logic arst_n;

	rrq_req_if req_ch();
	rrq_rsp_if rsp_ch();
	rrq_cfg_if cfg_ch();

	round_robin_ready_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.ID_BITS    (ID_BITS)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch),
		.cfg   (cfg_ch)
	);

	// Scheduler state as the block should hold it
	logic [THREAD_W-1:0] waiting_ids[$];
	logic [THREAD_W-1:0] running_id;
	sched_result_t       pending_results[$];

	int send_idle_pct;
	int recv_idle_pct;
	int error_count;
	int requests_sent;
	int results_checked;
	int switch_count;
	int empty_count;
	int full_count;
	int not_found_count;
	int cfg_writes;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic sched_result_t schedule_request(op_e op, logic [THREAD_W-1:0] id);
		sched_result_t       r;
		logic [THREAD_W-1:0] head;
		int                  pos;
		r.switched = 1'b0;
		r.status   = ST_OK;
		case (op)
			OP_SCHEDULE: begin
				if (waiting_ids.size() == 0) begin
					r.status = ST_EMPTY;
				end else begin
					head = waiting_ids.pop_front();
					waiting_ids.push_back(running_id);
					running_id = head;
					r.switched = 1'b1;
				end
			end
			OP_READY: begin
				if (waiting_ids.size() >= QUEUE_DEPTH)
					r.status = ST_FULL;
				else
					waiting_ids.push_back(id);
			end
			OP_NOT_READY: begin
				pos = -1;
				foreach (waiting_ids[i]) begin
					if (pos < 0 && waiting_ids[i] == id)
						pos = i;
				end
				if (pos < 0)
					r.status = ST_NOT_FOUND;
				else
					waiting_ids.delete(pos);
			end
			default: ;
		endcase
		r.running_thread = running_id;
		r.queue_count    = COUNT_W'(waiting_ids.size());
		return r;
	endfunction

	// Hold valid across back-to-back requests; drop it only while idling
	task automatic send_request(op_e op, logic [THREAD_W-1:0] id);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.thread_id <= id;
		do @(posedge clk); while (!req_ch.ready);
		pending_results.push_back(schedule_request(op, id));
		requests_sent++;
	endtask

	task automatic wait_results_drained();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_init_id(logic [THREAD_W-1:0] value);
		wait_results_drained();
		cfg_ch.valid   <= 1'b1;
		cfg_ch.init_id <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		waiting_ids.delete();
		running_id = value;
		cfg_writes++;
	endtask

	always @(posedge clk) begin
		sched_result_t exp;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: running_thread %0d status %0d",
					rsp_ch.running_thread, rsp_ch.status);
				error_count++;
			end else begin
				exp = pending_results.pop_front();
				results_checked++;
				if (rsp_ch.running_thread !== exp.running_thread) begin
					$error("running_thread: expected %0d, got %0d",
						exp.running_thread, rsp_ch.running_thread);
					error_count++;
				end
				if (rsp_ch.switched !== exp.switched) begin
					$error("switched: expected %0d, got %0d", exp.switched, rsp_ch.switched);
					error_count++;
				end
				if (rsp_ch.status !== exp.status) begin
					$error("status: expected %0d, got %0d", exp.status, rsp_ch.status);
					error_count++;
				end
				if (rsp_ch.queue_count !== exp.queue_count) begin
					$error("queue_count: expected %0d, got %0d",
						exp.queue_count, rsp_ch.queue_count);
					error_count++;
				end
				if (exp.switched)
					switch_count++;
				case (exp.status)
					ST_EMPTY:     empty_count++;
					ST_FULL:      full_count++;
					ST_NOT_FOUND: not_found_count++;
					default: ;
				endcase
			end
		end
	end

	task automatic test_reset_defaults();
		send_request(OP_SCHEDULE, 8'h00);
		send_request(OP_READY, 8'h42);
		send_request(OP_NOP, 8'hFF);
	endtask

	task automatic test_directed_cases();
		logic [THREAD_W-1:0] id;
		write_init_id(8'hFF);
		send_request(OP_SCHEDULE, 8'h3C);
		send_request(OP_NOT_READY, 8'hFF);
		send_request(OP_NOP, 8'hA5);
		// Fill with both extremes, walking ones and zeros, and one duplicate
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (i == 0)
				id = 8'h00;
			else if (i == 1)
				id = 8'hFF;
			else if (i < 10)
				id = 8'(1 << (i - 2));
			else if (i < 15)
				id = ~8'(1 << (i - 10));
			else
				id = 8'h01;
			send_request(OP_READY, id);
		end
		send_request(OP_READY, 8'h77);
		send_request(OP_NOT_READY, 8'h99);
		send_request(OP_NOT_READY, 8'h01);
		send_request(OP_SCHEDULE, 8'h00);
		send_request(OP_SCHEDULE, 8'hFF);
		send_request(OP_NOT_READY, 8'hFF);
		send_request(OP_READY, 8'h00);
	endtask

	task automatic send_random_request(bit grow);
		int                  roll;
		int                  ready_w;
		int                  remove_w;
		op_e                 op;
		logic [THREAD_W-1:0] id;
		roll     = $urandom_range(99);
		ready_w  = grow ? 55 : 15;
		remove_w = grow ? 10 : 50;
		if (roll < 5)
			op = OP_NOP;
		else if (roll < 5 + ready_w)
			op = OP_READY;
		else if (roll < 5 + ready_w + remove_w)
			op = OP_NOT_READY;
		else
			op = OP_SCHEDULE;
		// Mostly remove ids that are waiting; draw half of the other ids from a small pool for duplicates
		if (op == OP_NOT_READY && waiting_ids.size() > 0 && $urandom_range(99) < 75)
			id = waiting_ids[$urandom_range(waiting_ids.size() - 1)];
		else if ($urandom_range(1) == 0)
			id = THREAD_W'($urandom_range(15));
		else
			id = THREAD_W'($urandom_range(255));
		send_request(op, id);
	endtask

	task automatic test_random_traffic(int count, int send_pct, int recv_pct,
		logic [THREAD_W-1:0] start_thread);
		bit grow;
		int burst_left;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		write_init_id(start_thread);
		grow       = 1'b1;
		burst_left = $urandom_range(60, 20);
		for (int n = 0; n < count; n++) begin
			if (burst_left == 0) begin
				grow       = ~grow;
				burst_left = $urandom_range(60, 20);
			end
			burst_left--;
			// Pause once per run, halfway through, until the queue of results is empty
			if (n == count / 2)
				wait_results_drained();
			send_random_request(grow);
		end
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.operation = OP_NOP;
		req_ch.thread_id = '0;
		rsp_ch.ready   = 1'b0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.init_id = '0;
		running_id     = '0;
		send_idle_pct  = 27;
		recv_idle_pct  = 63;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_directed_cases();
		test_random_traffic(580, 27, 63, THREAD_W'($urandom_range(254, 1)));
		test_random_traffic(580, 63, 27, 8'h00);
		test_random_traffic(570, 0, 0, THREAD_W'($urandom_range(255)));

		wait_results_drained();
		repeat (5) @(posedge clk);
		$display("Covered %0d requests, %0d results checked, %0d initial-thread writes.",
			requests_sent, results_checked, cfg_writes);
		$display("Saw %0d switches, %0d empty schedules, %0d full drops, %0d ids not found.",
			switch_count, empty_count, full_count, not_found_count);
		if (error_count == 0)
			$display("round_robin_ready_queue test passed");
		else
			$display("round_robin_ready_queue test failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("round_robin_ready_queue test failed");
		$finish;
	end

endmodule
